FILE: design/jts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jts_pkg
// Shared types, codes and helpers for the JSON token scanner.
// ----------------------------------------------------------------------------
package jts_pkg;

  localparam int LINE_WIDTH   = 20;
  localparam int COLUMN_WIDTH = 16;
  localparam int OFFSET_WIDTH = 32;
  localparam int SPAN_WIDTH   = 16;
  localparam int QDEPTH       = 4;
  localparam int QCNT_WIDTH   = $clog2(QDEPTH + 1);

  localparam logic [2:0] MODE_IDLE    = 3'd0;
  localparam logic [2:0] MODE_STRING  = 3'd1;
  localparam logic [2:0] MODE_NUMBER  = 3'd2;
  localparam logic [2:0] MODE_KEYWORD = 3'd3;
  localparam logic [2:0] MODE_INVALID = 3'd4;

  localparam logic [3:0] KIND_LBRACE  = 4'd0;
  localparam logic [3:0] KIND_RBRACE  = 4'd1;
  localparam logic [3:0] KIND_LBRACK  = 4'd2;
  localparam logic [3:0] KIND_RBRACK  = 4'd3;
  localparam logic [3:0] KIND_COLON   = 4'd4;
  localparam logic [3:0] KIND_COMMA   = 4'd5;
  localparam logic [3:0] KIND_STRING  = 4'd6;
  localparam logic [3:0] KIND_NUMBER  = 4'd7;
  localparam logic [3:0] KIND_BOOLEAN = 4'd8;
  localparam logic [3:0] KIND_NULL    = 4'd9;
  localparam logic [3:0] KIND_ERROR   = 4'd10;
  localparam logic [3:0] KIND_END     = 4'd11;

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_NL_STRING  = 3'd1;
  localparam logic [2:0] ERR_UNCLOSED   = 3'd2;
  localparam logic [2:0] ERR_TWO_DEC    = 3'd3;
  localparam logic [2:0] ERR_TWO_EXP    = 3'd4;
  localparam logic [2:0] ERR_KEYWORD    = 3'd5;
  localparam logic [2:0] ERR_INVALID    = 3'd6;

  localparam logic [3:0] KW_NONE       = 4'd0;
  localparam logic [3:0] KW_TRUE_BASE  = 4'd1;
  localparam logic [3:0] KW_TRUE_END   = 4'd4;
  localparam logic [3:0] KW_FALSE_BASE = 4'd5;
  localparam logic [3:0] KW_FALSE_END  = 4'd9;
  localparam logic [3:0] KW_NULL_BASE  = 4'd10;
  localparam logic [3:0] KW_NULL_END   = 4'd13;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]  token_kind;
    logic [2:0]  error_kind;
    logic [19:0] token_line;
    logic [15:0] token_column;
    logic [31:0] start_offset;
    logic [15:0] span_length;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic [1:0] count;
    out_t       first;
    out_t       second;
  } pair_t;

  function automatic logic [19:0] clamp_line(input logic [LINE_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFFF) ? 20'hFFFFF : w[19:0];
  endfunction

  function automatic logic [15:0] clamp_col(input logic [COLUMN_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [31:0] clamp_off(input logic [OFFSET_WIDTH-1:0] v);
    logic [63:0] w;
    w = 64'(v);
    return (w > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  function automatic out_t make_token(input logic [3:0] kind, input logic [2:0] err,
                                      input logic [LINE_WIDTH-1:0] line,
                                      input logic [COLUMN_WIDTH-1:0] col,
                                      input logic [OFFSET_WIDTH-1:0] off,
                                      input logic [SPAN_WIDTH-1:0] span);
    out_t t;
    t.token_kind   = kind;
    t.error_kind   = err;
    t.token_line   = clamp_line(line);
    t.token_column = clamp_col(col);
    t.start_offset = clamp_off(off);
    t.span_length  = span;
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  function automatic logic [3:0] kw_first(input logic [7:0] c);
    case (c)
      "t":     return KW_TRUE_BASE;
      "f":     return KW_FALSE_BASE;
      "n":     return KW_NULL_BASE;
      default: return KW_NONE;
    endcase
  endfunction

  function automatic logic [7:0] kw_expect(input logic [3:0] m);
    case (m)
      4'd1:    return "r";
      4'd2:    return "u";
      4'd3:    return "e";
      4'd5:    return "a";
      4'd6:    return "l";
      4'd7:    return "s";
      4'd8:    return "e";
      4'd10:   return "u";
      4'd11:   return "l";
      4'd12:   return "l";
      default: return 8'd0;
    endcase
  endfunction

endpackage
`default_nettype wire

FILE: design/jts_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jts_scan
// Scanner state and per-byte token decision; gives up to two tokens a beat.
// ----------------------------------------------------------------------------
module jts_scan (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          go,
  input  wire jts_pkg::in_t  item,
  output jts_pkg::pair_t     pair
);

  logic [2:0]                       mode, mode_next;
  logic [jts_pkg::LINE_WIDTH-1:0]   line_cnt, line_cnt_next;
  logic [jts_pkg::COLUMN_WIDTH-1:0] col_cnt, col_cnt_next;
  logic [jts_pkg::OFFSET_WIDTH-1:0] off_cnt, off_cnt_next;
  logic [jts_pkg::COLUMN_WIDTH-1:0] st_col, st_col_next;
  logic [jts_pkg::OFFSET_WIDTH-1:0] st_off, st_off_next;
  logic [jts_pkg::SPAN_WIDTH-1:0]   span, span_next;
  logic                             dec, dec_next;
  logic                             expo, expo_next;
  logic [3:0]                       kw, kw_next;

  logic [7:0]                       c;
  logic                             eod, is_space, is_digit, is_alpha, is_term, is_numc;
  logic                             is_e, rescan, move, a_hit, b_hit;
  logic [jts_pkg::SPAN_WIDTH-1:0]   span_inc;
  jts_pkg::out_t                    a_tok, b_tok, kw_tok, first_t, second_t;
  logic [3:0]                       punct_kind;
  logic                             punct;

  always_comb begin
    c        = item.data_byte;
    eod      = item.req_type || (c == 8'd0);
    is_space = (c == " ") || (c >= 8'd9 && c <= 8'd13);
    is_digit = c inside {["0":"9"]};
    is_alpha = c inside {["a":"z"], ["A":"Z"]};
    is_term  = is_space || c inside {",", ":", "}", "]"};
    is_e     = c inside {"e", "E"};
    is_numc  = is_digit || c inside {"-", ".", "e", "E"};
    span_inc = (span == '1) ? span : span + 1'b1;
    punct    = 1'b1;
    case (c)
      "{":     punct_kind = jts_pkg::KIND_LBRACE;
      "}":     punct_kind = jts_pkg::KIND_RBRACE;
      "[":     punct_kind = jts_pkg::KIND_LBRACK;
      "]":     punct_kind = jts_pkg::KIND_RBRACK;
      ":":     punct_kind = jts_pkg::KIND_COLON;
      ",":     punct_kind = jts_pkg::KIND_COMMA;
      default: begin
        punct_kind = jts_pkg::KIND_END;
        punct      = 1'b0;
      end
    endcase

    if (kw == jts_pkg::KW_TRUE_END || kw == jts_pkg::KW_FALSE_END) begin
      kw_tok = jts_pkg::make_token(jts_pkg::KIND_BOOLEAN, jts_pkg::ERR_NONE,
                                   line_cnt, st_col, st_off, span);
    end else if (kw == jts_pkg::KW_NULL_END) begin
      kw_tok = jts_pkg::make_token(jts_pkg::KIND_NULL, jts_pkg::ERR_NONE,
                                   line_cnt, st_col, st_off, span);
    end else begin
      kw_tok = jts_pkg::make_token(jts_pkg::KIND_ERROR, jts_pkg::ERR_KEYWORD,
                                   line_cnt, st_col, st_off, span);
    end

    mode_next     = mode;
    line_cnt_next = line_cnt;
    col_cnt_next  = col_cnt;
    off_cnt_next  = off_cnt;
    st_col_next   = st_col;
    st_off_next   = st_off;
    span_next     = span;
    dec_next      = dec;
    expo_next     = expo;
    kw_next       = kw;
    rescan        = 1'b0;
    move          = 1'b0;
    a_hit         = 1'b0;
    b_hit         = 1'b0;
    a_tok         = jts_pkg::make_token(jts_pkg::KIND_ERROR, jts_pkg::ERR_NONE,
                                        line_cnt, st_col, st_off, span);
    b_tok         = jts_pkg::make_token(punct_kind, jts_pkg::ERR_NONE,
                                        line_cnt, col_cnt, off_cnt,
                                        jts_pkg::SPAN_WIDTH'(1));

    if (eod) begin
      a_hit = (mode != jts_pkg::MODE_IDLE);
      case (mode)
        jts_pkg::MODE_STRING:  a_tok.error_kind = jts_pkg::ERR_UNCLOSED;
        jts_pkg::MODE_NUMBER:  a_tok.token_kind = jts_pkg::KIND_NUMBER;
        jts_pkg::MODE_KEYWORD: a_tok = kw_tok;
        default:               a_tok.error_kind = jts_pkg::ERR_INVALID;
      endcase
      b_hit         = 1'b1;
      b_tok         = jts_pkg::make_token(jts_pkg::KIND_END, jts_pkg::ERR_NONE,
                                          line_cnt, col_cnt, off_cnt, '0);
      mode_next     = jts_pkg::MODE_IDLE;
      line_cnt_next = jts_pkg::LINE_WIDTH'(1);
      col_cnt_next  = jts_pkg::COLUMN_WIDTH'(1);
      off_cnt_next  = '0;
      st_col_next   = '0;
      st_off_next   = '0;
      span_next     = '0;
      dec_next      = 1'b0;
      expo_next     = 1'b0;
      kw_next       = jts_pkg::KW_NONE;
    end else begin
      case (mode)
        jts_pkg::MODE_STRING: begin
          if (c == "\"") begin
            a_hit     = 1'b1;
            a_tok     = jts_pkg::make_token(jts_pkg::KIND_STRING, jts_pkg::ERR_NONE,
                                            line_cnt, st_col, st_off, span_inc);
            span_next = span_inc;
            mode_next = jts_pkg::MODE_IDLE;
            move      = 1'b1;
          end else if (c == 8'd10) begin
            a_hit            = 1'b1;
            a_tok.error_kind = jts_pkg::ERR_NL_STRING;
            rescan           = 1'b1;
          end else begin
            span_next = span_inc;
            move      = 1'b1;
          end
        end
        jts_pkg::MODE_NUMBER: begin
          if (is_numc) begin
            if (c == "." && dec) begin
              a_hit            = 1'b1;
              a_tok.error_kind = jts_pkg::ERR_TWO_DEC;
              rescan           = 1'b1;
            end else if (is_e && expo) begin
              a_hit            = 1'b1;
              a_tok.error_kind = jts_pkg::ERR_TWO_EXP;
              rescan           = 1'b1;
            end else begin
              dec_next  = dec || (c == ".");
              expo_next = expo || is_e;
              span_next = span_inc;
              move      = 1'b1;
            end
          end else begin
            a_hit            = 1'b1;
            a_tok.token_kind = jts_pkg::KIND_NUMBER;
            rescan           = 1'b1;
          end
        end
        jts_pkg::MODE_KEYWORD: begin
          if (is_alpha) begin
            kw_next   = (jts_pkg::kw_expect(kw) != 8'd0 && c == jts_pkg::kw_expect(kw)) ?
                        kw + 4'd1 : jts_pkg::KW_NONE;
            span_next = span_inc;
            move      = 1'b1;
          end else begin
            a_hit  = 1'b1;
            a_tok  = kw_tok;
            rescan = 1'b1;
          end
        end
        jts_pkg::MODE_INVALID: begin
          if (is_term) begin
            a_hit            = 1'b1;
            a_tok.error_kind = jts_pkg::ERR_INVALID;
            rescan           = 1'b1;
          end else begin
            span_next = span_inc;
            move      = 1'b1;
          end
        end
        default: rescan = 1'b1;
      endcase

      if (rescan) begin
        mode_next = jts_pkg::MODE_IDLE;
        move      = 1'b1;
        if (punct) begin
          b_hit = 1'b1;
        end else if (!is_space) begin
          st_col_next = col_cnt;
          st_off_next = off_cnt;
          span_next   = jts_pkg::SPAN_WIDTH'(1);
          dec_next    = 1'b0;
          expo_next   = 1'b0;
          if (c == "\"") begin
            mode_next = jts_pkg::MODE_STRING;
          end else if (is_digit || c == "-") begin
            mode_next = jts_pkg::MODE_NUMBER;
          end else if (is_alpha) begin
            mode_next = jts_pkg::MODE_KEYWORD;
            kw_next   = jts_pkg::kw_first(c);
          end else begin
            mode_next = jts_pkg::MODE_INVALID;
          end
        end
      end

      if (move) begin
        if (c == 8'd10) begin
          line_cnt_next = (line_cnt == '1) ? line_cnt : line_cnt + 1'b1;
          col_cnt_next  = jts_pkg::COLUMN_WIDTH'(1);
        end else begin
          col_cnt_next  = (col_cnt == '1) ? col_cnt : col_cnt + 1'b1;
        end
        off_cnt_next = (off_cnt == '1) ? off_cnt : off_cnt + 1'b1;
      end
    end

    first_t  = a_hit ? a_tok : b_tok;
    second_t = b_tok;
    if (a_hit && b_hit) begin
      second_t.last_of_run = 1'b1;
    end else begin
      first_t.last_of_run = 1'b1;
    end
    pair.count  = go ? 2'({1'b0, a_hit} + {1'b0, b_hit}) : 2'd0;
    pair.first  = first_t;
    pair.second = second_t;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= jts_pkg::MODE_IDLE;
      line_cnt <= jts_pkg::LINE_WIDTH'(1);
      col_cnt  <= jts_pkg::COLUMN_WIDTH'(1);
      off_cnt  <= '0;
      st_col   <= '0;
      st_off   <= '0;
      span     <= '0;
      dec      <= 1'b0;
      expo     <= 1'b0;
      kw       <= jts_pkg::KW_NONE;
    end else if (go) begin
      mode     <= mode_next;
      line_cnt <= line_cnt_next;
      col_cnt  <= col_cnt_next;
      off_cnt  <= off_cnt_next;
      st_col   <= st_col_next;
      st_off   <= st_off_next;
      span     <= span_next;
      dec      <= dec_next;
      expo     <= expo_next;
      kw       <= kw_next;
    end
  end

endmodule
`default_nettype wire

FILE: design/jts_outq.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jts_outq
// Shifting token queue; takes up to two tokens a beat, presents the head.
// ----------------------------------------------------------------------------
module jts_outq (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire jts_pkg::pair_t pair,
  input  wire logic           tok_stall,
  output logic                room,
  output logic                tok_valid,
  output jts_pkg::out_t       tok
);

  logic [jts_pkg::QCNT_WIDTH-1:0] count, count_next, base;
  jts_pkg::out_t                  q [jts_pkg::QDEPTH];
  jts_pkg::out_t                  q_next [jts_pkg::QDEPTH];
  logic                           pop;

  always_comb begin
    pop        = (count != '0) && !tok_stall;
    base       = count - jts_pkg::QCNT_WIDTH'(pop);
    count_next = base + jts_pkg::QCNT_WIDTH'(pair.count);
    for (int i = 0; i < jts_pkg::QDEPTH; i++) begin
      if (pop && i < jts_pkg::QDEPTH - 1) begin
        q_next[i] = q[(i + 1) % jts_pkg::QDEPTH];
      end else begin
        q_next[i] = q[i];
      end
      if (pair.count != 2'd0 && base == jts_pkg::QCNT_WIDTH'(i)) begin
        q_next[i] = pair.first;
      end
      if (pair.count == 2'd2 && base + 1'b1 == jts_pkg::QCNT_WIDTH'(i)) begin
        q_next[i] = pair.second;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < jts_pkg::QDEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  assign room      = count <= jts_pkg::QCNT_WIDTH'(jts_pkg::QDEPTH - 2);
  assign tok_valid = count != '0;
  assign tok       = q[0];

endmodule
`default_nettype wire

FILE: design/json_token_scanner_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_token_scanner_core
// Byte-at-a-time JSON tokenizer with line, column, offset and span tracking.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall / req): one beat per document byte, or
//   an end-of-document beat (req_type high, or a zero byte).
//   tok channel (tok_valid / tok_stall / tok): one beat per token; each
//   request gives zero, one or two tokens, last_of_run marking the final one.
//   Throughput: one request per cycle while the receiver keeps up and the
//   queue has room; the output side moves one token per cycle while
//   tok_stall is low, so requests that give two tokens fill the queue.
//   Path: a taken request waits in the input register, then is scanned
//   into the four-entry token queue, whose head drives the tok channel.
//   The scanner advances only when the queue has room for two tokens; when
//   it has not, the input register holds and req_stall rises.
//   A stalled token stays at the queue head unchanged.
//   Reset empties the queue and input register and returns the scanner to
//   line 1, column 1, offset 0, between tokens. An end-of-document beat does
//   the same to the scanner after its tokens.
// ----------------------------------------------------------------------------
module json_token_scanner_core (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire jts_pkg::in_t  req,
  output logic               tok_valid,
  input  wire logic          tok_stall,
  output jts_pkg::out_t      tok
);

  jts_pkg::in_t   in_q;
  logic           in_full;
  logic           room;
  logic           go;
  jts_pkg::pair_t pair;

  assign go        = in_full && room;
  assign req_stall = in_full && !room;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (req_valid && !req_stall) begin
      in_full <= 1'b1;
    end else if (go) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      in_q <= req;
    end
  end

  jts_scan u_scan (
    .clk  (clk),
    .rst  (rst),
    .go   (go),
    .item (in_q),
    .pair (pair)
  );

  jts_outq u_outq (
    .clk       (clk),
    .rst       (rst),
    .pair      (pair),
    .tok_stall (tok_stall),
    .room      (room),
    .tok_valid (tok_valid),
    .tok       (tok)
  );

endmodule
`default_nettype wire

FILE: design/jts_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jts_checker
// Port-level checks on the token scanner, bound to its top level.
// ----------------------------------------------------------------------------
module jts_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          tok_valid,
  input wire logic          tok_stall,
  input wire jts_pkg::out_t tok
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !tok_valid)
    else $error("token shown after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_stall |=> tok_valid && $stable(tok))
    else $error("stalled token beat changed");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok.token_kind == jts_pkg::KIND_END |-> tok.last_of_run)
    else $error("end token not last of its request");

  a_err_clean: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok.token_kind != jts_pkg::KIND_ERROR |->
    tok.error_kind == jts_pkg::ERR_NONE)
    else $error("error code on a non-error token");

  a_span: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok.token_kind != jts_pkg::KIND_END |-> tok.span_length != 16'd0)
    else $error("empty span on a real token");

endmodule

bind json_token_scanner_core jts_checker u_jts_checker (.*);
`default_nettype wire
